// ----- rtl/arpc_pkg.sv -----
`default_nettype none

package arpc_pkg;

    // command codes
    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_RETRY  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_HOST_IP      = 3'd0;
    localparam logic [2:0] REG_SUBNET_MASK  = 3'd1;
    localparam logic [2:0] REG_ROUTER_IP    = 3'd2;
    localparam logic [2:0] REG_REMOTE_IP    = 3'd3;
    localparam logic [2:0] REG_RETRY_BUDGET = 3'd4;

    localparam logic [7:0] RETRY_BUDGET_RST = 8'd3;

    // one stored entry: address, hardware address, time stamp
    localparam int ENTRY_W = 32 + 48 + 8;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic [7:0]  now_time;
    } t_in;

    typedef struct packed {
        logic       miss;
        logic       retry_granted;
        logic [2:0] slot_used;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/arpc_ram.sv -----
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/arp_cache_update_lookup_unit.sv -----
`default_nettype none

// ARP cache with update, lookup and retry-take commands.
// Command channel: drive i_in and raise i_start; the word is taken at a rising
// edge where i_start is high and o_busy is low. Each command gives exactly one
// result word on o_out, marked by o_done for a single cycle; the receiver
// cannot stall it and must take it in that cycle.
// Update and lookup walk the table one entry per cycle through the single
// read port of the entry RAM, then pass through ST_DONE before o_done rises;
// the next command may be taken in the o_done cycle.
// Retry take and the unused command go straight to ST_DONE with no table walk.
// The sequential compare/age unit, fed by the RAM read port, sets this rate.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// o_cfg_ready is always high. Write it only while the block is idle.
// Reset (synchronous, active low) clears the per-entry valid flags, so every
// entry reads as empty, zeroes the retry counter and loads register defaults.
// Entries whose valid flag is clear read as all zero without a clearing pass.
module arp_cache_update_lookup_unit
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire t_in         i_in,
    output logic             o_done,
    output t_out             o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // configuration registers
    logic [31:0] r_host_ip;
    logic [31:0] r_subnet_mask;
    logic [31:0] r_router_ip;
    logic [31:0] r_remote_ip;
    logic [7:0]  r_retry_budget;

    // control state
    t_state      r_state;
    t_state      n_state;
    logic [7:0]  r_retry_left;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic        r_rd_on;
    logic [IW-1:0] r_rd_idx;
    logic        r_ck_on;
    logic [IW-1:0] r_ck_idx;
    logic        r_done;

    // command word and scan results
    logic [1:0]  r_cmd;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [7:0]  r_now;
    logic [31:0] r_hop;
    logic        r_hit;
    logic [IW-1:0] r_hit_idx;
    logic        r_emp;
    logic [IW-1:0] r_emp_idx;
    logic [7:0]  r_best_age;
    logic [IW-1:0] r_best_idx;
    logic        r_found;
    t_out        r_out;

    // RAM and datapath signals
    logic [ENTRY_W-1:0] w_rdata;
    logic [ENTRY_W-1:0] w_wdata;
    logic        w_we;
    logic [IW-1:0] w_slot;
    logic [IW+2:0] w_slot_ext;
    logic        w_accept;
    logic        w_scan_cmd;
    logic        w_ck_valid;
    logic [31:0] w_e_ip;
    logic [7:0]  w_e_stamp;
    logic [7:0]  w_age;
    logic        w_ip_ok;
    logic        w_e_ok;
    logic        w_last;
    t_out        w_res;
    logic [7:0]  w_retry_next;

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_out       = r_out;

    assign w_accept   = i_start && (r_state == ST_IDLE);
    assign w_scan_cmd = (i_in.command == CMD_UPDATE) || (i_in.command == CMD_LOOKUP);
    assign w_last     = r_ck_on && (r_ck_idx == LAST_IDX);

    // an entry never written reads as empty
    assign w_ck_valid = r_valid[r_ck_idx];
    assign w_e_ip     = w_ck_valid ? w_rdata[ENTRY_W-1 -: 32] : 32'd0;
    assign w_e_stamp  = w_ck_valid ? w_rdata[7:0] : 8'd0;
    assign w_age      = r_now - w_e_stamp;
    assign w_ip_ok    = (r_ip[15:0] != 16'd0) && (r_ip[31:16] != 16'd0);
    assign w_e_ok     = (w_e_ip[15:0] != 16'd0) && (w_e_ip[31:16] != 16'd0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_scan_cmd ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // pick the slot: refresh, then fill, then evict the oldest
    always_comb begin
        priority if (r_hit) begin
            w_slot = r_hit_idx;
        end else if (r_emp) begin
            w_slot = r_emp_idx;
        end else begin
            w_slot = r_best_idx;
        end
    end

    assign w_slot_ext = {3'd0, w_slot};
    assign w_wdata    = {r_ip, r_mac, r_now};

    // result word, table write and retry counter update
    always_comb begin
        w_we         = 1'b0;
        w_res        = '0;
        w_retry_next = r_retry_left;
        if (r_state == ST_DONE) begin
            unique case (r_cmd)
                CMD_UPDATE: begin
                    w_we            = 1'b1;
                    w_res.slot_used = w_slot_ext[2:0];
                    if (!r_hit) begin
                        w_retry_next = r_retry_budget;
                    end
                end
                CMD_LOOKUP: begin
                    w_res.miss = !r_found;
                end
                CMD_RETRY: begin
                    if (r_retry_left != 8'd0) begin
                        w_retry_next        = r_retry_left - 8'd1;
                        w_res.retry_granted = 1'b1;
                    end
                end
                default: begin
                    w_res = '0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_retry_left   <= 8'd0;
            r_valid        <= '0;
            r_rd_on        <= 1'b0;
            r_ck_on        <= 1'b0;
            r_done         <= 1'b0;
            r_host_ip      <= 32'd0;
            r_subnet_mask  <= 32'd0;
            r_router_ip    <= 32'd0;
            r_remote_ip    <= 32'd0;
            r_retry_budget <= RETRY_BUDGET_RST;
        end else begin
            r_state      <= n_state;
            r_retry_left <= w_retry_next;
            r_done       <= (r_state == ST_DONE);
            r_ck_on      <= r_rd_on;
            if (w_we) begin
                r_valid[w_slot] <= 1'b1;
            end
            // advance the read address across the table
            if (w_accept) begin
                r_rd_on <= w_scan_cmd;
            end else if (r_rd_on && (r_rd_idx == LAST_IDX)) begin
                r_rd_on <= 1'b0;
            end
            // take configuration words
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_HOST_IP:      r_host_ip      <= i_cfg_data;
                    REG_SUBNET_MASK:  r_subnet_mask  <= i_cfg_data;
                    REG_ROUTER_IP:    r_router_ip    <= i_cfg_data;
                    REG_REMOTE_IP:    r_remote_ip    <= i_cfg_data;
                    REG_RETRY_BUDGET: r_retry_budget <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // command word, scan trackers and result register
    always_ff @(posedge i_clk) begin
        r_ck_idx <= r_rd_idx;
        if (r_state == ST_DONE) begin
            r_out <= w_res;
        end
        if (w_accept) begin
            r_cmd      <= i_in.command;
            r_ip       <= i_in.ip_addr;
            r_mac      <= i_in.mac_addr;
            r_now      <= i_in.now_time;
            r_hop      <= ((r_remote_ip & r_subnet_mask) == (r_host_ip & r_subnet_mask))
                          ? r_remote_ip : r_router_ip;
            r_rd_idx   <= '0;
            r_hit      <= 1'b0;
            r_hit_idx  <= '0;
            r_emp      <= 1'b0;
            r_emp_idx  <= '0;
            r_best_age <= 8'd0;
            r_best_idx <= '0;
            r_found    <= 1'b0;
        end else begin
            if (r_rd_on && (r_rd_idx != LAST_IDX)) begin
                r_rd_idx <= r_rd_idx + IW'(1);
            end
            // check one entry per cycle
            if (r_ck_on) begin
                if (!r_hit && w_ip_ok && w_e_ok && (w_e_ip == r_ip)) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_ck_idx;
                end
                if (!r_emp && (w_e_ip == 32'd0)) begin
                    r_emp     <= 1'b1;
                    r_emp_idx <= r_ck_idx;
                end
                if ((r_now > w_e_stamp) && (w_age > r_best_age)) begin
                    r_best_age <= w_age;
                    r_best_idx <= r_ck_idx;
                end
                if (w_e_ip == r_hop) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire
